@@ design/fext_pkg.sv @@
// ----------------------------------------------------------------------------
// fext_pkg: shared types and constants of the first-fit extent allocator
// Widths, request and status codes, and the table write command.
// ----------------------------------------------------------------------------
package fext_pkg;

	localparam int EXTENTS   = 16;
	localparam int PAGE_BITS = 12;
	localparam int ADDR_W    = 32;
	localparam int END_W     = ADDR_W + 1;
	localparam int IDX_W     = $clog2(EXTENTS);
	localparam int CNT_W     = $clog2(EXTENTS + 1);

	localparam logic [END_W-1:0]  TOP_END   = END_W'(1) << ADDR_W;
	localparam logic [ADDR_W-1:0] PAGE_MASK = ~((ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1));

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RESERVE = 2'd1,
		REQ_FREE    = 2'd2,
		REQ_BAD     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] ext_start;
		logic [END_W-1:0]  ext_end;
	} tbl_wr_t;

endpackage

@@ design/fext_req_if.sv @@
// ----------------------------------------------------------------------------
// fext_req_if: request channel of the extent allocator
// valid/ready handshake carrying request type, address and size.
// ----------------------------------------------------------------------------
interface fext_req_if;
	import fext_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ADDR_W-1:0] req_addr;
	logic [ADDR_W-1:0] req_size;

	modport source (output valid, output req_type, output req_addr, output req_size,
		input ready);
	modport sink (input valid, input req_type, input req_addr, input req_size,
		output ready);
endinterface

@@ design/fext_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fext_rsp_if: response channel of the extent allocator
// valid/ready handshake carrying grant flag, grant address and status.
// ----------------------------------------------------------------------------
interface fext_rsp_if;
	import fext_pkg::*;

	logic              valid;
	logic              ready;
	logic              granted;
	logic [ADDR_W-1:0] grant_addr;
	logic [1:0]        status;

	modport source (output valid, output granted, output grant_addr, output status,
		input ready);
	modport sink (input valid, input granted, input grant_addr, input status,
		output ready);
endinterface

@@ design/fext_table.sv @@
// ----------------------------------------------------------------------------
// fext_table: free extent storage
// One write port and one read port over the start and end arrays.
// ----------------------------------------------------------------------------
module fext_table (
	input  logic                     clk,
	input  fext_pkg::tbl_wr_t        wr,
	input  logic [fext_pkg::IDX_W-1:0]  rd_idx,
	output logic [fext_pkg::ADDR_W-1:0] rd_start,
	output logic [fext_pkg::END_W-1:0]  rd_end
);
	import fext_pkg::*;

	logic [ADDR_W-1:0] start_q [EXTENTS];
	logic [END_W-1:0]  end_q   [EXTENTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			start_q[wr.idx] <= wr.ext_start;
			end_q[wr.idx]   <= wr.ext_end;
		end
	end

	assign rd_start = start_q[rd_idx];
	assign rd_end   = end_q[rd_idx];
endmodule

@@ design/first_fit_extent_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_extent_allocator: address-ordered free extent table
// Allocate first fit, reserve a range at a page-aligned base, free with coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   req: one transfer per request (req_type, req_addr, req_size).
//   rsp: one transfer per request (granted, grant_addr, status).
//   req.ready is high only while the sequencer is idle; one request is
//   worked on at a time.
//   A request runs through a scan over the stored extents, a decide step,
//   shift steps when an entry is inserted or removed, and a step that
//   loads the response register. Scan and shift together step over each
//   stored extent about once, paced by the single table read port; the
//   sequencer returns to idle before the next request is taken.
//   Bad requests (zero size, wrapping reserve or free range, unknown type)
//   skip the scan and go straight to the response step.
//   The response sits in an output register, so a new request is taken
//   while an earlier response waits; a stalled rsp holds the sequencer
//   only when the next response is ready to be loaded.
//   Reset empties the table (count zero); software frees the initial region.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator (
	input  logic clk,
	input  logic arst_n,
	fext_req_if.sink   req,
	fext_rsp_if.source rsp
);
	import fext_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_EXEC = 6'b000100,
		S_SHUP = 6'b001000,
		S_SHDN = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t            state_q;
	req_type_t         type_q;
	logic [ADDR_W-1:0] a_q;
	logic [END_W-1:0]  e_q;
	logic [ADDR_W-1:0] size_q;
	logic [CNT_W-1:0]  cnt_q, i_q, lo_q, k_q, d_q, pos_q;
	logic              lo_fnd_q;
	logic [ADDR_W-1:0] lo_start_q, hs_q, ins_s_q;
	logic [END_W-1:0]  last_end_q, he_q, ins_e_q;
	status_t           res_st_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              out_vld_q, out_granted_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_st_q;

	tbl_wr_t           wr;
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] rd_start;
	logic [END_W-1:0]  rd_end;

	fext_table u_table (
		.clk      (clk),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd_start (rd_start),
		.rd_end   (rd_end)
	);

	// request decode
	req_type_t         in_type;
	logic [ADDR_W-1:0] in_base;
	logic [END_W-1:0]  in_end;
	logic              in_bad;
	always_comb begin
		in_type = req_type_t'(req.req_type);
		in_base = (in_type == REQ_RESERVE) ? (req.req_addr & PAGE_MASK) : req.req_addr;
		in_end  = {1'b0, in_base} + {1'b0, req.req_size};
		in_bad  = (req.req_size == '0) || (in_type == REQ_BAD) ||
			((in_type != REQ_ALLOC) && (in_end > TOP_END));
	end

	// scan compares, one entry per cycle
	logic              in_rng, fit, hit, beyond;
	logic [CNT_W-1:0]  lo_eff, nk;
	logic              left, right;
	logic [END_W-1:0]  ns_alloc;
	logic [CNT_W:0]    shdn_src;
	always_comb begin
		in_rng   = i_q < cnt_q;
		fit      = (rd_end - {1'b0, rd_start}) >= {1'b0, size_q};
		hit      = ({1'b0, rd_start} <= {1'b0, a_q}) && (rd_end >= e_q);
		beyond   = {1'b0, rd_start} > e_q;
		lo_eff   = lo_fnd_q ? lo_q : i_q;
		nk       = i_q - lo_eff;
		left     = hs_q < a_q;
		right    = he_q > e_q;
		ns_alloc = {1'b0, hs_q} + {1'b0, size_q};
		shdn_src = {1'b0, k_q} + {1'b0, d_q};
	end

	always_comb begin
		unique case (state_q)
			S_SHUP:  rd_idx = IDX_W'(k_q - CNT_W'(1));
			S_SHDN:  rd_idx = shdn_src[IDX_W-1:0];
			default: rd_idx = i_q[IDX_W-1:0];
		endcase
	end

	// table write port
	always_comb begin
		wr = '0;
		unique case (state_q)
			S_EXEC: begin
				wr.idx = i_q[IDX_W-1:0];
				unique case (type_q)
					REQ_ALLOC: begin
						wr.en        = ns_alloc < he_q;
						wr.ext_start = ns_alloc[ADDR_W-1:0];
						wr.ext_end   = he_q;
					end
					REQ_RESERVE: begin
						wr.en        = (left || right) && !(left && right &&
							cnt_q >= CNT_W'(EXTENTS));
						wr.ext_start = left ? hs_q : e_q[ADDR_W-1:0];
						wr.ext_end   = left ? {1'b0, a_q} : he_q;
					end
					REQ_FREE: begin
						wr.en        = nk != '0;
						wr.idx       = lo_eff[IDX_W-1:0];
						wr.ext_start = (lo_start_q < a_q) ? lo_start_q : a_q;
						wr.ext_end   = (last_end_q > e_q) ? last_end_q : e_q;
					end
					default: wr.en = 1'b0;
				endcase
			end
			S_SHUP: begin
				wr.en = 1'b1;
				if (k_q > pos_q) begin
					wr.idx       = k_q[IDX_W-1:0];
					wr.ext_start = rd_start;
					wr.ext_end   = rd_end;
				end else begin
					wr.idx       = pos_q[IDX_W-1:0];
					wr.ext_start = ins_s_q;
					wr.ext_end   = ins_e_q;
				end
			end
			S_SHDN: begin
				wr.en        = shdn_src < {1'b0, cnt_q};
				wr.idx       = k_q[IDX_W-1:0];
				wr.ext_start = rd_start;
				wr.ext_end   = rd_end;
			end
			default: wr = '0;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					type_q     <= in_type;
					a_q        <= in_base;
					e_q        <= in_end;
					size_q     <= req.req_size;
					res_addr_q <= '0;
					res_st_q   <= in_bad ? ST_BAD : ST_OK;
					last_end_q <= '0;
					lo_q       <= '0;
					lo_start_q <= '0;
				end
			end
			S_SCAN: begin
				if (!in_rng) begin
					if (type_q != REQ_FREE)
						res_st_q <= ST_NOFIT;
				end else if ((type_q == REQ_ALLOC && fit) ||
					(type_q == REQ_RESERVE && hit)) begin
					hs_q <= rd_start;
					he_q <= rd_end;
				end else if (type_q == REQ_FREE && !beyond) begin
					if (!lo_fnd_q && rd_end >= {1'b0, a_q}) begin
						lo_q       <= i_q;
						lo_start_q <= rd_start;
					end
					last_end_q <= rd_end;
				end
			end
			S_EXEC: begin
				unique case (type_q)
					REQ_ALLOC: res_addr_q <= hs_q;
					REQ_RESERVE: begin
						if (left && right && cnt_q >= CNT_W'(EXTENTS))
							res_st_q <= ST_FULL;
						pos_q   <= i_q + CNT_W'(1);
						ins_s_q <= e_q[ADDR_W-1:0];
						ins_e_q <= he_q;
					end
					REQ_FREE: begin
						if (nk == '0 && cnt_q >= CNT_W'(EXTENTS))
							res_st_q <= ST_FULL;
						pos_q   <= i_q;
						ins_s_q <= a_q;
						ins_e_q <= e_q;
					end
					default: res_st_q <= ST_BAD;
				endcase
			end
			default: begin
			end
		endcase
		if (state_q == S_FIN && (!out_vld_q || rsp.ready)) begin
			out_granted_q <= res_st_q == ST_OK;
			out_addr_q    <= (res_st_q == ST_OK) ? res_addr_q : '0;
			out_st_q      <= res_st_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			i_q       <= '0;
			k_q       <= '0;
			d_q       <= '0;
			lo_fnd_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						i_q      <= '0;
						lo_fnd_q <= 1'b0;
						state_q  <= in_bad ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (!in_rng) begin
						state_q <= (type_q == REQ_FREE) ? S_EXEC : S_FIN;
					end else if ((type_q == REQ_ALLOC && fit) ||
						(type_q == REQ_RESERVE && hit) ||
						(type_q == REQ_FREE && beyond)) begin
						state_q <= S_EXEC;
					end else begin
						if (type_q == REQ_FREE && rd_end >= {1'b0, a_q})
							lo_fnd_q <= 1'b1;
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					unique case (type_q)
						REQ_ALLOC: begin
							if (ns_alloc >= he_q) begin
								k_q     <= i_q;
								d_q     <= CNT_W'(1);
								state_q <= S_SHDN;
							end
						end
						REQ_RESERVE: begin
							if (left && right) begin
								if (cnt_q < CNT_W'(EXTENTS)) begin
									k_q     <= cnt_q;
									state_q <= S_SHUP;
								end
							end else if (!left && !right) begin
								k_q     <= i_q;
								d_q     <= CNT_W'(1);
								state_q <= S_SHDN;
							end
						end
						REQ_FREE: begin
							if (nk == '0) begin
								if (cnt_q < CNT_W'(EXTENTS)) begin
									k_q     <= cnt_q;
									state_q <= S_SHUP;
								end
							end else if (nk > CNT_W'(1)) begin
								k_q     <= lo_eff + CNT_W'(1);
								d_q     <= nk - CNT_W'(1);
								state_q <= S_SHDN;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_SHUP: begin
					if (k_q > pos_q) begin
						k_q <= k_q - CNT_W'(1);
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_SHDN: begin
					if (shdn_src < {1'b0, cnt_q}) begin
						k_q <= k_q + CNT_W'(1);
					end else begin
						cnt_q   <= cnt_q - d_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready      = state_q == S_IDLE;
	assign rsp.valid      = out_vld_q;
	assign rsp.granted    = out_granted_q;
	assign rsp.grant_addr = out_addr_q;
	assign rsp.status     = out_st_q;
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the first-fit extent allocator
// Drives allocate, reserve, free and bad requests under random idling and stalls,
// keeps its own copy of the free extent table and checks every response.
// ----------------------------------------------------------------------------
module tb_top;
	import fext_pkg::*;

	typedef struct packed {
		logic              granted;
		logic [ADDR_W-1:0] grant_addr;
		status_t           status;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fext_req_if req ();
	fext_rsp_if rsp ();

	first_fit_extent_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #6 clk = ~clk;

	// free extent table as the block should hold it
	logic [ADDR_W-1:0] ext_lo [EXTENTS];
	logic [END_W-1:0]  ext_hi [EXTENTS];
	int                ext_num;

	reply_t replies_due [$];
	int     err_count;
	int     idle_pct;
	int     stall_pct;
	int     quiet_cycles;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	function automatic void drop_extent(input int i);
		for (int k = i; k + 1 < ext_num; k++) begin
			ext_lo[k] = ext_lo[k+1];
			ext_hi[k] = ext_hi[k+1];
		end
		ext_num--;
	endfunction

	function automatic status_t carve_first_fit(input logic [ADDR_W-1:0] size,
		output logic [ADDR_W-1:0] addr);
		logic [END_W-1:0] ns;
		addr = '0;
		for (int i = 0; i < ext_num; i++) begin
			if (ext_hi[i] - {1'b0, ext_lo[i]} >= {1'b0, size}) begin
				ns = {1'b0, ext_lo[i]} + {1'b0, size};
				addr = ext_lo[i];
				if (ns >= ext_hi[i]) drop_extent(i);
				else ext_lo[i] = ns[ADDR_W-1:0];
				return ST_OK;
			end
		end
		return ST_NOFIT;
	endfunction

	function automatic status_t reserve_range(input logic [ADDR_W-1:0] addr,
		input logic [ADDR_W-1:0] size);
		logic [ADDR_W-1:0] va;
		logic [END_W-1:0]  ve;
		logic              left, right;
		va = addr & PAGE_MASK;
		ve = {1'b0, va} + {1'b0, size};
		if (ve > TOP_END) return ST_BAD;
		for (int i = 0; i < ext_num; i++) begin
			if (ext_lo[i] <= va && ext_hi[i] >= ve) begin
				left = ext_lo[i] < va;
				right = ext_hi[i] > ve;
				if (left && right) begin
					if (ext_num >= EXTENTS) return ST_FULL;
					for (int k = ext_num; k > i + 1; k--) begin
						ext_lo[k] = ext_lo[k-1];
						ext_hi[k] = ext_hi[k-1];
					end
					ext_lo[i+1] = ve[ADDR_W-1:0];
					ext_hi[i+1] = ext_hi[i];
					ext_hi[i] = {1'b0, va};
					ext_num++;
				end else if (left) begin
					ext_hi[i] = {1'b0, va};
				end else if (right) begin
					ext_lo[i] = ve[ADDR_W-1:0];
				end else begin
					drop_extent(i);
				end
				return ST_OK;
			end
		end
		return ST_NOFIT;
	endfunction

	function automatic status_t free_range(input logic [ADDR_W-1:0] addr,
		input logic [ADDR_W-1:0] size);
		logic [ADDR_W-1:0] tlo [EXTENTS+1];
		logic [END_W-1:0]  thi [EXTENTS+1];
		logic [END_W-1:0]  fe;
		int                n, m;
		logic              placed;
		fe = {1'b0, addr} + {1'b0, size};
		n = 0;
		m = 0;
		placed = 1'b0;
		if (fe > TOP_END) return ST_BAD;
		for (int i = 0; i < ext_num; i++) begin
			if (!placed && ext_lo[i] > addr) begin
				tlo[n] = addr;
				thi[n] = fe;
				n++;
				placed = 1'b1;
			end
			tlo[n] = ext_lo[i];
			thi[n] = ext_hi[i];
			n++;
		end
		if (!placed) begin
			tlo[n] = addr;
			thi[n] = fe;
			n++;
		end
		for (int i = 0; i < n; i++) begin
			if (m > 0 && {1'b0, tlo[i]} <= thi[m-1]) begin
				if (thi[i] > thi[m-1]) thi[m-1] = thi[i];
			end else begin
				tlo[m] = tlo[i];
				thi[m] = thi[i];
				m++;
			end
		end
		if (m > EXTENTS) return ST_FULL;
		for (int i = 0; i < m; i++) begin
			ext_lo[i] = tlo[i];
			ext_hi[i] = thi[i];
		end
		ext_num = m;
		return ST_OK;
	endfunction

	function automatic reply_t predict_reply(input req_type_t kind,
		input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] size);
		reply_t            r;
		logic [ADDR_W-1:0] ga;
		status_t           st;
		ga = '0;
		if (size == '0 || kind == REQ_BAD) st = ST_BAD;
		else if (kind == REQ_ALLOC) st = carve_first_fit(size, ga);
		else if (kind == REQ_RESERVE) st = reserve_range(addr, size);
		else st = free_range(addr, size);
		r.granted = (st == ST_OK);
		r.grant_addr = (st == ST_OK) ? ga : '0;
		r.status = st;
		return r;
	endfunction

	// valid stays high into the next request unless the sender idles
	task automatic send_request(input req_type_t kind, input logic [ADDR_W-1:0] addr,
		input logic [ADDR_W-1:0] size);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.req_addr <= addr;
		req.req_size <= size;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		replies_due.push_back(predict_reply(kind, addr, size));
		@(negedge clk);
	endtask

	// response checker and receiver stalls
	always @(posedge clk) begin
		reply_t want;
		if (rsp.valid && rsp.ready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("unexpected response", rsp.status, 0);
			end else begin
				want = replies_due.pop_front();
				if (rsp.granted !== want.granted)
					report_mismatch("granted", rsp.granted, want.granted);
				if (rsp.grant_addr !== want.grant_addr)
					report_mismatch("grant_addr", rsp.grant_addr, want.grant_addr);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
			end
		end
	end

	always @(negedge clk) rsp.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [ADDR_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'h1 << $urandom_range(31);
			2: return $urandom_range(3) == 0 ? 32'h0 : 32'hffff_ffff;
			default: return $urandom_range(1, 8) << $urandom_range(8, 16);
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		int i;
		if (ext_num > 0 && $urandom_range(2) != 0) begin
			i = $urandom_range(ext_num - 1);
			return ext_lo[i] + ($urandom_range(7) << PAGE_BITS);
		end
		if ($urandom_range(3) == 0) return $urandom();
		return $urandom_range(255) << $urandom_range(8, 20);
	endfunction

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (2 * EXTENTS + 8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_request(REQ_ALLOC, 32'h0, 32'h10);
		send_request(REQ_FREE, 32'h0, 32'h0);
		send_request(REQ_BAD, 32'h1000, 32'h10);
		send_request(REQ_FREE, 32'hffff_f000, 32'h2000);
		send_request(REQ_FREE, 32'h0010_0000, 32'h0010_0000);
		send_request(REQ_FREE, 32'hffff_0000, 32'h0001_0000);
		send_request(REQ_FREE, 32'h0030_0000, 32'h1000);
		send_request(REQ_FREE, 32'h0020_0000, 32'h0010_0000);
		send_request(REQ_FREE, 32'h0018_0000, 32'h0020_0000);
		send_request(REQ_ALLOC, 32'hffff_ffff, 32'h100);
		send_request(REQ_ALLOC, 32'h0, 32'hffff_ffff);
		send_request(REQ_RESERVE, 32'h0015_0fff, 32'h3000);
		send_request(REQ_RESERVE, 32'h0010_0000, 32'h100);
		send_request(REQ_RESERVE, 32'hffff_f000, 32'h1000);
		send_request(REQ_RESERVE, 32'hffff_f123, 32'h2000);
		send_request(REQ_RESERVE, 32'h8000_0000, 32'h1000);
		send_request(REQ_ALLOC, 32'h0, 32'h0010_0000);
		send_request(REQ_FREE, 32'h0, 32'hffff_ffff);
		send_request(REQ_FREE, 32'hffff_ffff, 32'h1);
		send_request(REQ_RESERVE, 32'h0, 32'hffff_ffff);
		send_request(REQ_ALLOC, 32'h0, 32'h1);
		// fill the table with separate pages, then try splits and frees
		for (int i = 0; i < EXTENTS + 1; i++)
			send_request(REQ_FREE, 32'h1000_0000 + (i << 16), 32'h2000);
		send_request(REQ_RESERVE, 32'h1000_0000, 32'h1000);
		send_request(REQ_RESERVE, 32'h1001_0000, 32'h1000);
		send_request(REQ_FREE, 32'h2000_0000, 32'h100);
	endtask

	task automatic test_random(input int count);
		req_type_t kind;
		int        r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 35) kind = REQ_ALLOC;
			else if (r < 60) kind = REQ_RESERVE;
			else if (r < 97) kind = REQ_FREE;
			else kind = REQ_BAD;
			send_request(kind, pick_addr(), pick_size());
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_ALLOC;
		req.req_addr = '0;
		req.req_size = '0;
		rsp.ready = 1'b0;
		ext_num = 0;
		err_count = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(110);
		idle_pct = 88;
		test_random(110);
		idle_pct = 0;
		stall_pct = 88;
		test_random(110);
		idle_pct = 9;
		stall_pct = 9;
		test_random(110);
		idle_pct = 0;
		stall_pct = 0;

		wait_drained();
		if (err_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

@@ sim.f @@
design/fext_pkg.sv
design/fext_req_if.sv
design/fext_rsp_if.sv
design/fext_table.sv
design/first_fit_extent_allocator.sv
test/tb_top.sv
